FILE: hw/rtl/two_phase_pwm_soft_start_ramp_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-phase PWM soft-start ramp.
// Each macro wraps one clocked concurrent assertion on clk.
// ---------------------------------------------------------------------------
`ifndef TWO_PHASE_PWM_SOFT_START_RAMP_MACROS_SVH
`define TWO_PHASE_PWM_SOFT_START_RAMP_MACROS_SVH

// Checked only outside reset.
`define PR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, during reset too.
`define PR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pwm_ramp_pkg.sv
// ---------------------------------------------------------------------------
// pwm_ramp_pkg
// Types, constants and lookup functions for the PWM soft-start ramp.
// ---------------------------------------------------------------------------
package pwm_ramp_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SWEEP_COUNT = 144;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [TIME_BITS-1:0] HOLD_US = TIME_BITS'(2000000);

  localparam logic [7:0] CMD_STOP_LIMIT = 8'd25;
  localparam logic [7:0] CMD_SWEEP      = 8'd99;

  localparam logic [11:0] PWM_FULL    = 12'd4095;
  // ceil(2^26 / 100); exact quotient for every dividend below 2^20.
  localparam logic [19:0] RECIP_100   = 20'd671089;
  localparam int          RECIP_SHIFT = 26;

  localparam logic [6:0]  RST_START_LEVEL  = 7'd25;
  localparam logic [6:0]  RST_QUICK_TARGET = 7'd35;
  localparam logic [3:0]  RST_COARSE_STEP  = 4'd3;
  localparam logic [31:0] RST_COARSE_DELAY = 32'd200000;
  localparam logic [6:0]  RST_FINAL_TARGET = 7'd70;
  localparam logic [3:0]  RST_FINE_INC     = 4'd1;
  localparam logic [31:0] RST_FINE_DELAY   = 32'd500000;
  localparam logic [31:0] RST_TEST_RUN     = 32'd2000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL,
    REG_QUICK_TARGET,
    REG_COARSE_STEP,
    REG_COARSE_DELAY,
    REG_FINAL_TARGET,
    REG_FINE_INC,
    REG_FINE_DELAY,
    REG_TEST_RUN
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_WAIT,
    PH_OFF
  } phase_t;

  typedef struct packed {
    logic                 kind;
    logic [TIME_BITS-1:0] now_us;
    logic [7:0]           command_byte;
  } in_item_t;

  typedef struct packed {
    logic        pwm_write;
    logic [11:0] pwm_value;
    logic        ramp_active;
    logic        auto_test_active;
    logic [7:0]  test_number;
    logic [1:0]  test_phase;
    logic [6:0]  level_percent;
  } out_item_t;

  function automatic logic [6:0] tab_start(input logic [1:0] d);
    logic [6:0] v;
    case (d)
      2'd0:    v = 7'd20;
      2'd1:    v = 7'd22;
      2'd2:    v = 7'd24;
      2'd3:    v = 7'd25;
      default: v = 7'd20;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] tab_quick(input logic [1:0] d);
    logic [6:0] v;
    case (d)
      2'd0:    v = 7'd33;
      2'd1:    v = 7'd35;
      2'd2:    v = 7'd36;
      default: v = 7'd33;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] tab_step(input logic [1:0] d);
    logic [3:0] v;
    case (d)
      2'd0:    v = 4'd2;
      2'd1:    v = 4'd3;
      2'd2:    v = 4'd4;
      2'd3:    v = 4'd5;
      default: v = 4'd2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] tab_delay(input logic [1:0] d);
    logic [31:0] v;
    case (d)
      2'd0:    v = 32'd50000;
      2'd1:    v = 32'd100000;
      2'd2:    v = 32'd200000;
      default: v = 32'd50000;
    endcase
    return v;
  endfunction

  // round(pct * 4095 / 100), saturated to 12 bits.
  function automatic logic [11:0] pct_to_cmp(input logic [6:0] pct);
    logic [19:0] x;
    logic [39:0] prod;
    logic [13:0] q;
    x    = ({1'b0, pct, 12'd0} - {13'd0, pct}) + 20'd50;
    prod = x * RECIP_100;
    q    = prod[RECIP_SHIFT +: 14];
    return (q > {2'b00, PWM_FULL}) ? PWM_FULL : q[11:0];
  endfunction

endpackage

FILE: hw/rtl/pwm_ramp_in_if.sv
// ---------------------------------------------------------------------------
// pwm_ramp_in_if
// Input channel: a tick or a command byte, with the current time.
// ---------------------------------------------------------------------------
interface pwm_ramp_in_if;
  import pwm_ramp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [TIME_BITS-1:0] now_us;
  logic [7:0]           command_byte;

  modport source (output valid, output kind, output now_us, output command_byte,
                  input ready);
  modport sink (input valid, input kind, input now_us, input command_byte,
                output ready);
endinterface

FILE: hw/rtl/pwm_ramp_out_if.sv
// ---------------------------------------------------------------------------
// pwm_ramp_out_if
// Result channel: PWM write request and ramp and sweep status.
// ---------------------------------------------------------------------------
interface pwm_ramp_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_write;
  logic [11:0] pwm_value;
  logic        ramp_active;
  logic        auto_test_active;
  logic [7:0]  test_number;
  logic [1:0]  test_phase;
  logic [6:0]  level_percent;

  modport source (output valid, output pwm_write, output pwm_value, output ramp_active,
                  output auto_test_active, output test_number, output test_phase,
                  output level_percent, input ready);
  modport sink (input valid, input pwm_write, input pwm_value, input ramp_active,
                input auto_test_active, input test_number, input test_phase,
                input level_percent, output ready);
endinterface

FILE: hw/rtl/two_phase_pwm_soft_start_ramp.sv
// ---------------------------------------------------------------------------
// two_phase_pwm_soft_start_ramp
// Motor PWM soft-start ramp with a two-phase ramp and an auto-test sweep.
//
// Each input beat on in_ch is a time tick or a command byte, both stamped
// with the free-running microsecond time. Each accepted beat yields exactly
// one result beat on out_ch carrying an optional PWM compare write and the
// ramp and sweep status after that beat.
// Ramp and sweep settings go in through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while no beat is in flight, which the
// block does not enforce; writes take effect at once. A beat passes the
// input register, then the state update and result register. One beat is
// accepted every cycle unless out_ch stalls; a single state pass per beat.
// When out_ch stalls, the result register holds and the input register
// still takes one more beat, after which in_ch.ready drops until the
// result is taken. Synchronous reset restores the default settings, stops
// the ramp and sweep, and empties both registers.
// ---------------------------------------------------------------------------
`include "two_phase_pwm_soft_start_ramp_macros.svh"

module two_phase_pwm_soft_start_ramp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pwm_ramp_in_if.sink                          in_ch,
  pwm_ramp_out_if.source                       out_ch,
  input  logic                                 cfg_we,
  input  logic [pwm_ramp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwm_ramp_pkg::CFG_W-1:0]       cfg_wdata
);
  import pwm_ramp_pkg::*;

  // Pipeline registers
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      adv, proc;

  // Settings and working ramp parameters
  logic [6:0]           w_start_r, w_start_nxt;
  logic [6:0]           w_quick_r, w_quick_nxt;
  logic [3:0]           w_step_r, w_step_nxt;
  logic [31:0]          w_delay_r, w_delay_nxt;
  logic [6:0]           w_final_r, w_final_nxt;
  logic [3:0]           fine_inc_r, fine_inc_nxt;
  logic [31:0]          fine_delay_r, fine_delay_nxt;
  logic [31:0]          test_run_r, test_run_nxt;

  // Ramp and sweep state
  logic [6:0]           level_r, level_nxt;
  logic                 ramp_on_r, ramp_on_nxt;
  logic [TIME_BITS-1:0] last_step_r, last_step_nxt;
  logic [7:0]           last_cmd_r, last_cmd_nxt;
  logic                 sweep_on_r, sweep_on_nxt;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           sweep_idx_r, sweep_idx_nxt;
  logic [TIME_BITS-1:0] run_start_r, run_start_nxt;
  logic [TIME_BITS-1:0] phase_start_r, phase_start_nxt;
  logic [1:0]           dg_delay_r, dg_delay_nxt;
  logic [1:0]           dg_step_r, dg_step_nxt;
  logic [1:0]           dg_quick_r, dg_quick_nxt;
  logic [1:0]           dg_start_r, dg_start_nxt;

  // Per-beat working values
  logic                 wr;
  logic [11:0]          wr_val;
  logic                 done;
  logic                 step;
  logic [3:0]           inc;
  logic [31:0]          dly;
  logic [7:0]           lvl_sum;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since_run, since_phase, since_step;
  logic [1:0]           ld_start, ld_quick, ld_step, ld_delay;
  logic                 load;

  assign adv         = !out_vld_r || out_ch.ready;
  assign proc        = in_vld_r && adv;
  assign in_ch.ready = !in_vld_r || adv;

  assign now         = in_item_r.now_us;
  assign since_run   = now - run_start_r;
  assign since_phase = now - phase_start_r;
  assign since_step  = now - last_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.kind         <= in_ch.kind;
      in_item_r.now_us       <= in_ch.now_us;
      in_item_r.command_byte <= in_ch.command_byte;
    end
  end

  always_comb begin
    w_start_nxt     = w_start_r;
    w_quick_nxt     = w_quick_r;
    w_step_nxt      = w_step_r;
    w_delay_nxt     = w_delay_r;
    w_final_nxt     = w_final_r;
    fine_inc_nxt    = fine_inc_r;
    fine_delay_nxt  = fine_delay_r;
    test_run_nxt    = test_run_r;
    level_nxt       = level_r;
    ramp_on_nxt     = ramp_on_r;
    last_step_nxt   = last_step_r;
    last_cmd_nxt    = last_cmd_r;
    sweep_on_nxt    = sweep_on_r;
    phase_nxt       = phase_r;
    sweep_idx_nxt   = sweep_idx_r;
    run_start_nxt   = run_start_r;
    phase_start_nxt = phase_start_r;
    dg_delay_nxt    = dg_delay_r;
    dg_step_nxt     = dg_step_r;
    dg_quick_nxt    = dg_quick_r;
    dg_start_nxt    = dg_start_r;
    wr              = 1'b0;
    wr_val          = 12'd0;
    done            = 1'b0;
    step            = 1'b0;
    inc             = 4'd0;
    dly             = 32'd0;
    lvl_sum         = {1'b0, level_r};
    load            = 1'b0;
    ld_start        = 2'd0;
    ld_quick        = 2'd0;
    ld_step         = 2'd0;
    ld_delay        = 2'd0;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_START_LEVEL:  w_start_nxt    = cfg_wdata[6:0];
        REG_QUICK_TARGET: w_quick_nxt    = cfg_wdata[6:0];
        REG_COARSE_STEP:  w_step_nxt     = cfg_wdata[3:0];
        REG_COARSE_DELAY: w_delay_nxt    = cfg_wdata;
        REG_FINAL_TARGET: w_final_nxt    = cfg_wdata[6:0];
        REG_FINE_INC:     fine_inc_nxt   = cfg_wdata[3:0];
        REG_FINE_DELAY:   fine_delay_nxt = cfg_wdata;
        REG_TEST_RUN:     test_run_nxt   = cfg_wdata;
        default:          ;
      endcase
    end

    if (proc) begin
      if (in_item_r.kind) begin
        if (in_item_r.command_byte != last_cmd_r) begin
          last_cmd_nxt = in_item_r.command_byte;
          if (in_item_r.command_byte < CMD_STOP_LIMIT) begin
            ramp_on_nxt  = 1'b0;
            sweep_on_nxt = 1'b0;
            wr           = 1'b1;
            level_nxt    = w_start_r;
          end else if (in_item_r.command_byte == CMD_SWEEP) begin
            sweep_on_nxt  = 1'b1;
            sweep_idx_nxt = 8'd0;
            phase_nxt     = PH_RUN;
            dg_delay_nxt  = 2'd0;
            dg_step_nxt   = 2'd0;
            dg_quick_nxt  = 2'd0;
            dg_start_nxt  = 2'd0;
            load          = 1'b1;
          end else if (in_item_r.command_byte > CMD_STOP_LIMIT) begin
            ramp_on_nxt = 1'b1;
          end
        end
      end else begin
        if (sweep_on_r) begin
          case (phase_r)
            PH_RUN: begin
              if (since_run >= test_run_r) begin
                ramp_on_nxt     = 1'b0;
                phase_nxt       = PH_WAIT;
                phase_start_nxt = now;
                done            = 1'b1;
              end
            end
            PH_WAIT: begin
              if (since_phase >= HOLD_US) begin
                wr              = 1'b1;
                phase_nxt       = PH_OFF;
                phase_start_nxt = now;
                done            = 1'b1;
              end
            end
            PH_OFF: begin
              if (since_phase >= HOLD_US) begin
                sweep_idx_nxt = sweep_idx_r + 8'd1;
                phase_nxt     = PH_RUN;
                done          = 1'b1;
                // Mixed-radix digits of the combination index: 4 x 3 x 4 x 3.
                if (dg_delay_r == 2'd2) begin
                  dg_delay_nxt = 2'd0;
                  if (dg_step_r == 2'd3) begin
                    dg_step_nxt = 2'd0;
                    if (dg_quick_r == 2'd2) begin
                      dg_quick_nxt = 2'd0;
                      dg_start_nxt = dg_start_r + 2'd1;
                    end else begin
                      dg_quick_nxt = dg_quick_r + 2'd1;
                    end
                  end else begin
                    dg_step_nxt = dg_step_r + 2'd1;
                  end
                end else begin
                  dg_delay_nxt = dg_delay_r + 2'd1;
                end
                if ({1'b0, sweep_idx_r} + 9'd1 >= 9'(SWEEP_COUNT)) begin
                  sweep_on_nxt = 1'b0;
                end else begin
                  load = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end

        if (!done && ramp_on_r) begin
          if (level_r >= w_final_r) begin
            if (!sweep_on_r) begin
              ramp_on_nxt = 1'b0;
            end
          end else if (level_r >= w_start_r && level_r < w_quick_r) begin
            inc  = w_step_r;
            dly  = w_delay_r;
            step = 1'b1;
          end else if (level_r >= w_quick_r) begin
            inc  = fine_inc_r;
            dly  = fine_delay_r;
            step = 1'b1;
          end
          if (step && since_step >= dly) begin
            wr            = 1'b1;
            wr_val        = pct_to_cmp(level_r);
            lvl_sum       = {1'b0, level_r} + {4'd0, inc};
            level_nxt     = lvl_sum[7] ? 7'd127 : lvl_sum[6:0];
            last_step_nxt = now;
          end
        end
      end

      if (load) begin
        ld_start      = dg_start_nxt;
        ld_quick      = dg_quick_nxt;
        ld_step       = dg_step_nxt;
        ld_delay      = dg_delay_nxt;
        w_start_nxt   = tab_start(ld_start);
        w_quick_nxt   = tab_quick(ld_quick);
        w_step_nxt    = tab_step(ld_step);
        w_delay_nxt   = tab_delay(ld_delay);
        w_final_nxt   = tab_quick(ld_quick) + 7'd5;
        ramp_on_nxt   = 1'b1;
        level_nxt     = tab_start(ld_start);
        last_step_nxt = now;
        run_start_nxt = now;
      end
    end

    out_item_nxt.pwm_write        = wr;
    out_item_nxt.pwm_value        = wr_val;
    out_item_nxt.ramp_active      = ramp_on_nxt;
    out_item_nxt.auto_test_active = sweep_on_nxt;
    out_item_nxt.test_number      = sweep_idx_nxt;
    out_item_nxt.test_phase       = phase_nxt;
    out_item_nxt.level_percent    = level_nxt;

    if (proc) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_start_r     <= RST_START_LEVEL;
      w_quick_r     <= RST_QUICK_TARGET;
      w_step_r      <= RST_COARSE_STEP;
      w_delay_r     <= RST_COARSE_DELAY;
      w_final_r     <= RST_FINAL_TARGET;
      fine_inc_r    <= RST_FINE_INC;
      fine_delay_r  <= RST_FINE_DELAY;
      test_run_r    <= RST_TEST_RUN;
      level_r       <= RST_START_LEVEL;
      ramp_on_r     <= 1'b0;
      last_step_r   <= '0;
      last_cmd_r    <= 8'd0;
      sweep_on_r    <= 1'b0;
      phase_r       <= PH_RUN;
      sweep_idx_r   <= 8'd0;
      run_start_r   <= '0;
      phase_start_r <= '0;
      dg_delay_r    <= 2'd0;
      dg_step_r     <= 2'd0;
      dg_quick_r    <= 2'd0;
      dg_start_r    <= 2'd0;
      out_vld_r     <= 1'b0;
    end else begin
      w_start_r     <= w_start_nxt;
      w_quick_r     <= w_quick_nxt;
      w_step_r      <= w_step_nxt;
      w_delay_r     <= w_delay_nxt;
      w_final_r     <= w_final_nxt;
      fine_inc_r    <= fine_inc_nxt;
      fine_delay_r  <= fine_delay_nxt;
      test_run_r    <= test_run_nxt;
      level_r       <= level_nxt;
      ramp_on_r     <= ramp_on_nxt;
      last_step_r   <= last_step_nxt;
      last_cmd_r    <= last_cmd_nxt;
      sweep_on_r    <= sweep_on_nxt;
      phase_r       <= phase_nxt;
      sweep_idx_r   <= sweep_idx_nxt;
      run_start_r   <= run_start_nxt;
      phase_start_r <= phase_start_nxt;
      dg_delay_r    <= dg_delay_nxt;
      dg_step_r     <= dg_step_nxt;
      dg_quick_r    <= dg_quick_nxt;
      dg_start_r    <= dg_start_nxt;
      out_vld_r     <= out_vld_nxt;
    end
    if (proc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.pwm_write        = out_item_r.pwm_write;
  assign out_ch.pwm_value        = out_item_r.pwm_value;
  assign out_ch.ramp_active      = out_item_r.ramp_active;
  assign out_ch.auto_test_active = out_item_r.auto_test_active;
  assign out_ch.test_number      = out_item_r.test_number;
  assign out_ch.test_phase       = out_item_r.test_phase;
  assign out_ch.level_percent    = out_item_r.level_percent;

  `PR_ASSERT(a_beat_gives_result, proc |=> out_vld_r, "processed beat produced no result")
  `PR_ASSERT(a_sweep_only_on_beat, !proc |=> $stable(sweep_on_r) && $stable(sweep_idx_r),
             "sweep state changed without a beat")
  `PR_ASSERT(a_sweep_idx_range, sweep_idx_r <= 8'(SWEEP_COUNT),
             "sweep index beyond combination count")

endmodule
